// ===== rtl/rct_pkg.sv =====
// Shared types and constants for the RESP command tokenizer.
package rct_pkg;

  // Width of the accepted-token count carried on every result.
  localparam int CountW = 31;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Entries in the queue between the parser and the result sequencer.
  localparam int QueueDepth = 4;

  // Characters the parser looks for.
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  typedef enum logic [2:0] {
    KIND_BYTE   = 3'd0,
    KIND_ACCEPT = 3'd1,
    KIND_DROP   = 3'd2,
    KIND_DONE   = 3'd3,
    KIND_EMPTY  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    TOK_NONE   = 2'd0,
    TOK_ACCEPT = 2'd1,
    TOK_DROP   = 2'd2
  } tok_event_t;

  // Everything one input byte causes, as up to three results in a fixed order:
  // a payload byte, a token event, and the end-of-message report.
  typedef struct packed {
    logic              has_byte;
    logic [7:0]        byte_val;
    tok_event_t        tok;
    logic              has_end;
    logic              end_empty;
    logic [CountW-1:0] count_before;
    logic [CountW-1:0] count_after;
  } rct_entry_t;

endpackage

// ===== rtl/rct_queue.sv =====
// Small register queue that decouples the byte parser from the result sequencer.
module rct_queue
  import rct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  rct_entry_t push_entry,
  output logic       push_ready,
  output logic       head_valid,
  output rct_entry_t head_entry,
  input  logic       pop
);

  localparam int PtrW = $clog2(QueueDepth);

  rct_entry_t        store [QueueDepth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [PtrW:0]     fill;

  logic do_push;
  logic do_pop;

  assign push_ready = (fill != (PtrW + 1)'(QueueDepth));
  assign head_valid = (fill != '0);
  assign head_entry = store[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/rct_front.sv =====
// Byte parser: tracks the message state and classifies each byte into results.
module rct_front
  import rct_pkg::*;
#(
  parameter int unsigned NUMBER_LIMIT = 2147483647
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last,
  output logic       q_push,
  output rct_entry_t q_entry,
  input  logic       q_ready
);

  localparam int ValW = $clog2(64'(NUMBER_LIMIT) + 64'd1);
  localparam int ProdW = ValW + 4;

  typedef enum logic [2:0] {
    PH_AWAIT, PH_INLINE, PH_HEADER, PH_DOLLAR,
    PH_LENGTH, PH_PAYLOAD, PH_TRAILER, PH_STOPPED
  } phase_t;

  typedef enum logic [1:0] {ST_LEAD, ST_SIGN, ST_DIGITS, ST_TAIL} stage_t;
  typedef enum logic [1:0] {NUM_MORE, NUM_OK, NUM_ERR} num_res_t;

  phase_t            phase, phase_next;
  logic [ValW-1:0]   elements_left, elements_left_next;
  logic [ValW-1:0]   number_value, number_value_next;
  stage_t            stage, stage_next;
  logic              neg, neg_next;
  logic              ovf, ovf_next;
  logic              cr_seen, cr_seen_next;
  logic [ValW-1:0]   payload_left, payload_left_next;
  logic              trailer_one, trailer_one_next;
  logic [CountW-1:0] accepted_tokens, accepted_tokens_next;
  logic              in_token, in_token_next;

  // Number line evaluation for the current byte.
  num_res_t        nres;
  logic [ValW-1:0] nv;
  stage_t          nst;
  logic            nneg, novf, ncr;
  logic [ProdW-1:0] prod;
  logic            digit_go;

  logic is_space, is_digit, accept, emit_byte, tok_acc, tok_drop;
  logic [CountW-1:0] count_inc;
  phase_t ph_eff;

  assign in_ready  = q_ready;
  assign accept    = in_valid && in_ready;
  assign is_space  = (data_byte == ChSpace) || (data_byte >= ChTab && data_byte <= ChCr);
  assign is_digit  = (data_byte >= ChZero) && (data_byte <= ChNine);
  assign prod      = (ProdW'(number_value) << 3) + (ProdW'(number_value) << 1)
                   + ProdW'(data_byte[3:0]);
  assign count_inc = (accepted_tokens == CountMax) ? accepted_tokens
                                                   : accepted_tokens + 1'b1;

  always_comb begin
    nres     = NUM_MORE;
    nv       = number_value;
    nst      = stage;
    nneg     = neg;
    novf     = ovf;
    ncr      = cr_seen;
    digit_go = 1'b0;
    if (cr_seen && data_byte == ChLf) begin
      if (stage == ST_LEAD || stage == ST_SIGN || ovf || (neg && number_value != '0)) begin
        nres = NUM_ERR;
      end else begin
        nres = NUM_OK;
      end
    end else begin
      ncr = (data_byte == ChCr);
      unique case (stage)
        ST_LEAD: begin
          if (is_digit) begin
            digit_go = 1'b1;
          end else if (is_space) begin
            nres = NUM_MORE;
          end else if (data_byte == ChPlus || data_byte == ChMinus) begin
            nst  = ST_SIGN;
            nneg = (data_byte == ChMinus);
          end else begin
            nres = NUM_ERR;
          end
        end
        ST_SIGN: begin
          if (is_digit) begin
            digit_go = 1'b1;
          end else begin
            nres = NUM_ERR;
          end
        end
        ST_DIGITS: begin
          if (is_digit) begin
            digit_go = 1'b1;
          end else begin
            nst = ST_TAIL;
          end
        end
        ST_TAIL: begin
          nres = NUM_MORE;
        end
        default: begin
          nres = NUM_MORE;
        end
      endcase
      if (digit_go) begin
        nst = ST_DIGITS;
        if (!ovf) begin
          if (prod > ProdW'(NUMBER_LIMIT)) begin
            novf = 1'b1;
          end else begin
            nv = prod[ValW-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    phase_next           = phase;
    elements_left_next   = elements_left;
    number_value_next    = number_value;
    stage_next           = stage;
    neg_next             = neg;
    ovf_next             = ovf;
    cr_seen_next         = cr_seen;
    payload_left_next    = payload_left;
    trailer_one_next     = trailer_one;
    accepted_tokens_next = accepted_tokens;
    in_token_next        = in_token;
    emit_byte            = 1'b0;
    tok_acc              = 1'b0;
    tok_drop             = 1'b0;

    // The first byte picks the mode; a non-star byte is handled as whitespace text.
    ph_eff = (phase == PH_AWAIT && data_byte != ChStar) ? PH_INLINE : phase;

    unique case (ph_eff)
      PH_AWAIT: begin
        phase_next        = PH_HEADER;
        number_value_next = '0;
        stage_next        = ST_LEAD;
        neg_next          = 1'b0;
        ovf_next          = 1'b0;
        cr_seen_next      = 1'b0;
      end
      PH_INLINE: begin
        phase_next = PH_INLINE;
        if (is_space) begin
          if (in_token) begin
            tok_acc              = 1'b1;
            accepted_tokens_next = count_inc;
            in_token_next        = 1'b0;
          end
        end else begin
          in_token_next = 1'b1;
          emit_byte     = 1'b1;
        end
      end
      PH_HEADER, PH_LENGTH: begin
        number_value_next = nv;
        stage_next        = nst;
        neg_next          = nneg;
        ovf_next          = novf;
        cr_seen_next      = ncr;
        if (nres == NUM_ERR) begin
          phase_next = PH_STOPPED;
        end else if (nres == NUM_OK) begin
          if (ph_eff == PH_HEADER) begin
            elements_left_next = number_value;
            phase_next = (number_value == '0) ? PH_STOPPED : PH_DOLLAR;
          end else begin
            payload_left_next = number_value;
            in_token_next     = 1'b1;
            if (number_value == '0) begin
              trailer_one_next = 1'b0;
              phase_next       = PH_TRAILER;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
      end
      PH_DOLLAR: begin
        if (data_byte == ChDollar) begin
          phase_next        = PH_LENGTH;
          number_value_next = '0;
          stage_next        = ST_LEAD;
          neg_next          = 1'b0;
          ovf_next          = 1'b0;
          cr_seen_next      = 1'b0;
        end else begin
          phase_next = PH_STOPPED;
        end
      end
      PH_PAYLOAD: begin
        emit_byte         = 1'b1;
        payload_left_next = payload_left - 1'b1;
        if (payload_left == ValW'(1)) begin
          trailer_one_next = 1'b0;
          phase_next       = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        // Two trailer bytes follow each payload; their values are not checked.
        if (!trailer_one) begin
          trailer_one_next = 1'b1;
        end else begin
          trailer_one_next     = 1'b0;
          tok_acc              = 1'b1;
          accepted_tokens_next = count_inc;
          in_token_next        = 1'b0;
          elements_left_next   = elements_left - 1'b1;
          phase_next = (elements_left == ValW'(1)) ? PH_STOPPED : PH_DOLLAR;
        end
      end
      PH_STOPPED: begin
        phase_next = PH_STOPPED;
      end
      default: begin
        phase_next = PH_STOPPED;
      end
    endcase

    // A token still open at the end of the message is confirmed in text mode
    // and dropped otherwise.
    if (last && in_token_next) begin
      if (phase_next == PH_INLINE) begin
        tok_acc              = 1'b1;
        accepted_tokens_next = count_inc;
      end else begin
        tok_drop = 1'b1;
      end
    end

    q_entry.has_byte     = emit_byte;
    q_entry.byte_val     = data_byte;
    q_entry.tok          = tok_acc ? TOK_ACCEPT : (tok_drop ? TOK_DROP : TOK_NONE);
    q_entry.has_end      = last;
    q_entry.end_empty    = (accepted_tokens_next == '0);
    q_entry.count_before = accepted_tokens;
    q_entry.count_after  = accepted_tokens_next;

    if (last) begin
      phase_next           = PH_AWAIT;
      elements_left_next   = '0;
      number_value_next    = '0;
      stage_next           = ST_LEAD;
      neg_next             = 1'b0;
      ovf_next             = 1'b0;
      cr_seen_next         = 1'b0;
      payload_left_next    = '0;
      trailer_one_next     = 1'b0;
      accepted_tokens_next = '0;
      in_token_next        = 1'b0;
    end
  end

  assign q_push = accept && (emit_byte || tok_acc || tok_drop || last);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_AWAIT;
      elements_left   <= '0;
      number_value    <= '0;
      stage           <= ST_LEAD;
      neg             <= 1'b0;
      ovf             <= 1'b0;
      cr_seen         <= 1'b0;
      payload_left    <= '0;
      trailer_one     <= 1'b0;
      accepted_tokens <= '0;
      in_token        <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      elements_left   <= elements_left_next;
      number_value    <= number_value_next;
      stage           <= stage_next;
      neg             <= neg_next;
      ovf             <= ovf_next;
      cr_seen         <= cr_seen_next;
      payload_left    <= payload_left_next;
      trailer_one     <= trailer_one_next;
      accepted_tokens <= accepted_tokens_next;
      in_token        <= in_token_next;
    end
  end

endmodule

// ===== rtl/rct_back.sv =====
// Result sequencer: expands queued entries into results, one per ready cycle.
module rct_back
  import rct_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  rct_entry_t        head_entry,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        result_kind,
  output logic [7:0]        token_byte,
  output logic [CountW-1:0] token_count,
  output logic              final_result
);

  logic [2:0] done;
  logic [2:0] pending;
  logic [2:0] remain;
  logic [2:0] sel;
  logic [2:0] after;
  kind_t      kind;
  logic       fire;

  assign pending = {head_entry.has_end, head_entry.tok != TOK_NONE, head_entry.has_byte};
  assign remain  = pending & ~done;
  assign sel     = remain & (~remain + 3'd1);
  assign after   = remain & ~sel;

  always_comb begin
    if (sel[0]) begin
      kind = KIND_BYTE;
    end else if (sel[1]) begin
      kind = (head_entry.tok == TOK_ACCEPT) ? KIND_ACCEPT : KIND_DROP;
    end else begin
      kind = head_entry.end_empty ? KIND_EMPTY : KIND_DONE;
    end
  end

  assign out_valid    = head_valid;
  assign result_kind  = kind;
  assign token_byte   = sel[0] ? head_entry.byte_val : 8'd0;
  assign token_count  = sel[0] ? head_entry.count_before : head_entry.count_after;
  assign final_result = (after == 3'd0);
  assign fire         = out_valid && out_ready;
  assign pop          = fire && final_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else if (fire) begin
      done <= final_result ? 3'd0 : (done | sel);
    end
  end

endmodule

// ===== rtl/resp_command_tokenizer_core.sv =====
// Top level of the RESP command tokenizer: parser, result queue and sequencer.
//
// The block takes one command message a byte per request (last marks its final
// byte) and emits token results. A message starting with '*' is parsed as a
// RESP array of '$'-prefixed bulk strings; any other message is split on
// whitespace. Payload bytes stream out as they arrive (kind 0), each token is
// then confirmed (kind 1) or, if the message ends inside it, dropped (kind 2),
// and every message closes with exactly one done (kind 3) or empty-command
// error (kind 4) result. Each input byte is parsed in the cycle it is accepted,
// so input requests are taken one per cycle while the result queue has room.
// A byte causes zero to three results; the sequencer delivers one result per
// cycle while ready, so sustained input rate is one byte per cycle whenever
// bytes average at most one result each, which holds for payload and header
// bytes. The four-entry queue between parser and sequencer absorbs bursts of
// multi-result bytes (token ends and message ends). Number lines saturate
// into an error above NUMBER_LIMIT. No clearing pass is needed after reset.
module resp_command_tokenizer_core
  import rct_pkg::*;
#(
  parameter int unsigned NUMBER_LIMIT = 2147483647
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        result_kind,
  output logic [7:0]        token_byte,
  output logic [CountW-1:0] token_count,
  output logic              final_result
);

  // Parser to queue.
  logic       q_push;
  logic       q_ready;
  rct_entry_t q_entry;

  // Queue to sequencer.
  logic       head_valid;
  logic       head_pop;
  rct_entry_t head_entry;

  rct_front #(
    .NUMBER_LIMIT (NUMBER_LIMIT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last      (last),
    .q_push    (q_push),
    .q_entry   (q_entry),
    .q_ready   (q_ready)
  );

  rct_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .push_ready (q_ready),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (head_pop)
  );

  // The sequencer drives the result channel straight from the queue registers.
  rct_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_entry   (head_entry),
    .pop          (head_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .token_byte   (token_byte),
    .token_count  (token_count),
    .final_result (final_result)
  );

endmodule

// ===== test/resp_command_tokenizer_core_tb.sv =====
// Self-checking testbench for resp_command_tokenizer_core with a built-in tokenizer predictor.
`timescale 1ns / 1ps

module resp_command_tokenizer_core_tb;
  import rct_pkg::*;

  localparam int unsigned NumLimit = 2147483647;
  localparam int RandomRequests = 40;
  localparam int LongHold = 150;
  localparam int SettleCycles = 16;
  localparam int WatchdogLimit = 3000;
  localparam int MaxReports = 10;

  // Parser phases as the predictor tracks them.
  typedef enum logic [2:0] {
    ST_AWAIT, ST_INLINE, ST_HEADER, ST_DOLLAR,
    ST_LENGTH, ST_PAYLOAD, ST_TRAILER, ST_STOPPED
  } parse_st_t;

  // Outcome of feeding one byte to a number line.
  typedef enum logic [1:0] {LINE_OPEN, LINE_GOOD, LINE_BAD} line_t;

  // Receiver stall patterns.
  typedef enum logic [1:0] {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_RHYTHM} rx_mode_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        tbyte;
    logic [CountW-1:0] count;
    logic              closing;
  } tok_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        data_byte;
  logic              last;
  logic              out_valid;
  logic              out_ready;
  logic [2:0]        result_kind;
  logic [7:0]        token_byte;
  logic [CountW-1:0] token_count;
  logic              final_result;

  resp_command_tokenizer_core #(
    .NUMBER_LIMIT(NumLimit)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .last(last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_kind(result_kind),
    .token_byte(token_byte),
    .token_count(token_count),
    .final_result(final_result)
  );

  always #4 clk = ~clk;

  // Predictor state, mirroring the tokenizer.
  parse_st_t         pst;
  logic [CountW-1:0] elems_left;
  logic [31:0]       num_value;
  logic [1:0]        num_stage;
  logic              num_neg;
  logic              num_ovf;
  logic              cr_seen;
  logic [CountW-1:0] bytes_left;
  logic [1:0]        trail_left;
  logic [CountW-1:0] accepted;
  logic              in_tok;

  tok_result_t due_results[$];
  logic [7:0]  msg_buf[$];

  int errors = 0;
  int results_seen = 0;
  int sent_requests = 0;
  int random_requests = 0;
  int messages_sent = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  int hold_request = 0;

  function automatic logic is_space(input logic [7:0] b);
    return b == ChSpace || (b >= ChTab && b <= ChCr);
  endfunction

  // Appends one byte to the message being built.
  function automatic void buf_byte(input logic [7:0] b);
    msg_buf.insert(msg_buf.size(), b);
  endfunction

  function automatic void clear_parser();
    pst = ST_AWAIT;
    elems_left = '0;
    num_value = '0;
    num_stage = '0;
    num_neg = 1'b0;
    num_ovf = 1'b0;
    cr_seen = 1'b0;
    bytes_left = '0;
    trail_left = '0;
    accepted = '0;
    in_tok = 1'b0;
  endfunction

  function automatic void start_number();
    num_value = '0;
    num_stage = '0;
    num_neg = 1'b0;
    num_ovf = 1'b0;
    cr_seen = 1'b0;
  endfunction

  function automatic void post_result(input kind_t k, input logic [7:0] b);
    tok_result_t r;
    r.kind = k;
    r.tbyte = b;
    r.count = accepted;
    r.closing = 1'b0;
    due_results.insert(due_results.size(), r);
  endfunction

  function automatic void accept_token();
    if (accepted != CountMax) accepted++;
    in_tok = 1'b0;
    post_result(KIND_ACCEPT, 8'h00);
  endfunction

  // A number line ends at the first CR LF; digits accumulate until the first
  // non-digit, after which the rest of the line is ignored.
  function automatic line_t feed_number(input logic [7:0] b);
    logic        is_digit;
    logic [63:0] grown;
    is_digit = (b >= ChZero && b <= ChNine);
    if (cr_seen && b == ChLf) begin
      if (num_stage < 2'd2 || num_ovf || (num_neg && num_value != 0)) return LINE_BAD;
      return LINE_GOOD;
    end
    cr_seen = (b == ChCr);
    if (num_stage == 2'd0) begin
      if (is_space(b)) return LINE_OPEN;
      if (b == ChPlus || b == ChMinus) begin
        num_neg = (b == ChMinus);
        num_stage = 2'd1;
        return LINE_OPEN;
      end
      if (!is_digit) return LINE_BAD;
      num_stage = 2'd2;
    end else if (num_stage == 2'd1) begin
      if (!is_digit) return LINE_BAD;
      num_stage = 2'd2;
    end
    if (num_stage == 2'd2) begin
      if (is_digit) begin
        if (!num_ovf) begin
          grown = {32'd0, num_value} * 64'd10 + {56'd0, b} - 64'd48;
          if (grown > 64'(NumLimit)) num_ovf = 1'b1;
          else num_value = grown[31:0];
        end
      end else begin
        num_stage = 2'd3;
      end
    end
    return LINE_OPEN;
  endfunction

  // Works out every result that one accepted request causes.
  task automatic tokenize_byte(input logic [7:0] b, input logic l);
    int          base;
    line_t       verdict;
    base = due_results.size();
    if (pst == ST_AWAIT && b == ChStar) begin
      pst = ST_HEADER;
      start_number();
    end else begin
      if (pst == ST_AWAIT) pst = ST_INLINE;
      case (pst)
        ST_INLINE: begin
          if (is_space(b)) begin
            if (in_tok) accept_token();
          end else begin
            in_tok = 1'b1;
            post_result(KIND_BYTE, b);
          end
        end
        ST_HEADER: begin
          verdict = feed_number(b);
          if (verdict == LINE_BAD) begin
            pst = ST_STOPPED;
          end else if (verdict == LINE_GOOD) begin
            elems_left = num_value[CountW-1:0];
            pst = (elems_left == 0) ? ST_STOPPED : ST_DOLLAR;
          end
        end
        ST_DOLLAR: begin
          if (b == ChDollar) begin
            pst = ST_LENGTH;
            start_number();
          end else begin
            pst = ST_STOPPED;
          end
        end
        ST_LENGTH: begin
          verdict = feed_number(b);
          if (verdict == LINE_BAD) begin
            pst = ST_STOPPED;
          end else if (verdict == LINE_GOOD) begin
            bytes_left = num_value[CountW-1:0];
            in_tok = 1'b1;
            if (bytes_left == 0) begin
              trail_left = 2'd2;
              pst = ST_TRAILER;
            end else begin
              pst = ST_PAYLOAD;
            end
          end
        end
        ST_PAYLOAD: begin
          post_result(KIND_BYTE, b);
          bytes_left--;
          if (bytes_left == 0) begin
            trail_left = 2'd2;
            pst = ST_TRAILER;
          end
        end
        ST_TRAILER: begin
          trail_left--;
          if (trail_left == 0) begin
            accept_token();
            elems_left--;
            pst = (elems_left == 0) ? ST_STOPPED : ST_DOLLAR;
          end
        end
        default: begin
        end
      endcase
    end
    if (l) begin
      // A token cut off by the end of the message is dropped, except a
      // whitespace-split token, which the end of the message completes.
      if (in_tok) begin
        if (pst == ST_INLINE) begin
          accept_token();
        end else begin
          in_tok = 1'b0;
          post_result(KIND_DROP, 8'h00);
        end
      end
      post_result((accepted == 0) ? KIND_EMPTY : KIND_DONE, 8'h00);
      clear_parser();
    end
    if (due_results.size() > base) begin
      due_results[due_results.size() - 1].closing = 1'b1;
    end
  endtask

  task automatic log_error(input string msg);
    errors++;
    if (errors <= MaxReports) $display("ERROR: %s", msg);
  endtask

  // Predicts on every accepted request, checks every accepted result and
  // watches for a hang.
  always @(posedge clk) begin : monitor
    tok_result_t want;
    if (rst) begin
      clear_parser();
      quiet_cycles = 0;
    end else begin
      if (in_valid && in_ready) tokenize_byte(data_byte, last);
      if (out_valid && out_ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          log_error($sformatf("unexpected result kind=%0d byte=%02h count=%0d final=%0b",
                              result_kind, token_byte, token_count, final_result));
        end else begin
          want = due_results.pop_front();
          if (result_kind !== want.kind || token_byte !== want.tbyte ||
              token_count !== want.count || final_result !== want.closing) begin
            log_error({$sformatf("expected kind=%0d byte=%02h count=%0d final=%0b, ",
                                 want.kind, want.tbyte, want.count, want.closing),
                       $sformatf("got kind=%0d byte=%02h count=%0d final=%0b",
                                 result_kind, token_byte, token_count, final_result)});
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Watchdog: no request or result moved for %0d cycles", quiet_cycles);
        $display("** resp_command_tokenizer_core: FAILED **");
        $finish;
      end
    end
  end

  // Receiver: switches among stall patterns, and honors a long hold-off when
  // one is ordered so that the block fills up and stalls its input.
  always @(posedge clk) begin : receiver
    int       hold_left;
    int       mode_left;
    int       tick;
    rx_mode_t rx_mode;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
      mode_left = 0;
      tick = 0;
      rx_mode = RX_FREE;
    end else begin
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 60);
        end
        mode_left--;
        tick++;
        case (rx_mode)
          RX_FREE:   out_ready <= 1'b1;
          RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: out_ready <= ($urandom_range(0, 9) < 3);
          default:   out_ready <= (tick % 3 != 0);
        endcase
      end
    end
  end

  // Offers one request; bursts of back-to-back requests alternate with gaps.
  task automatic send_request(input logic [7:0] b, input logic l);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last <= l;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    sent_requests++;
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_buf.size(); i++) send_request(msg_buf[i], i == msg_buf.size() - 1);
    msg_buf.delete();
    messages_sent++;
  endtask

  // Stops offering requests and waits until every expected result has come.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) buf_byte(s[i]);
  endtask

  task automatic add_crlf();
    buf_byte(ChCr);
    buf_byte(ChLf);
  endtask

  task automatic add_line(input string s);
    add_text(s);
    add_crlf();
  endtask

  function automatic logic [7:0] any_space();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? ChSpace : ChTab + 8'(k);
  endfunction

  // A number line with occasional leading whitespace, sign and trailing junk.
  task automatic add_count(input int v);
    if ($urandom_range(0, 4) == 0) buf_byte(any_space());
    if ($urandom_range(0, 9) == 0) buf_byte(ChPlus);
    add_text($sformatf("%0d", v));
    if ($urandom_range(0, 9) == 0) add_text("x");
    add_crlf();
  endtask

  task automatic test_inline_split();
    add_text("SET k\tv");
    send_message();
    add_text(" ");
    send_message();
    buf_byte(8'h00);
    buf_byte(8'hFF);
    add_line("x");
    send_message();
    add_text("*");
    send_message();
  endtask

  task automatic test_array_framing();
    add_line("*2");
    add_line("$3");
    add_line("foo");
    add_line("$0");
    add_text("xy");
    send_message();
    add_line("*0");
    add_text("$1");
    send_message();
    add_line("* +1x");
    add_line("$\t1junk");
    buf_byte(8'hFF);
    buf_byte(8'h00);
    buf_byte(8'h00);
    send_message();
    add_line("*1");
    add_text("#");
    send_message();
  endtask

  task automatic test_number_lines();
    add_line("*-1");
    add_text("z");
    send_message();
    add_line("*-0");
    add_line("$1");
    add_line("A");
    send_message();
    add_line("*");
    send_message();
    add_text("*+");
    add_crlf();
    send_message();
    add_line("*2147483648");
    add_text("$");
    send_message();
    add_text("*1\n");
    add_crlf();
    add_line("$1");
    add_line("z");
    send_message();
    // A lone CR counts as leading whitespace and does not end the line.
    add_text("*");
    buf_byte(ChCr);
    add_line("5");
    add_line("$1");
    add_line("q");
    send_message();
  endtask

  task automatic test_truncation();
    add_line("*1");
    add_line("$2147483647");
    add_text("ab");
    send_message();
    add_line("*1");
    add_text("$1");
    buf_byte(ChCr);
    send_message();
    add_line("*3");
    add_line("$1");
    add_text("q");
    buf_byte(ChCr);
    send_message();
    add_line("*2");
    add_line("$1");
    add_line("a");
    add_line("$4");
    add_text("bc");
    send_message();
    add_line("*1");
    add_line("$0");
    buf_byte(ChCr);
    send_message();
  endtask

  // The receiver holds off for a long stretch while short tokens keep coming,
  // so the result queue fills and the input must stall.
  task automatic test_backpressure();
    hold_request = LongHold;
    for (int i = 0; i < 8; i++) begin
      buf_byte(8'(8'h61 + i));
      if (i != 7) buf_byte(ChSpace);
    end
    send_message();
  endtask

  // Mostly well-formed arrays with random payloads, some of them damaged,
  // plus whitespace-split messages and plain noise.
  task automatic test_random_traffic();
    int start_count;
    int pick;
    int elems;
    int len;
    int cut;
    int n;
    start_count = sent_requests;
    while (sent_requests - start_count < RandomRequests) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        elems = $urandom_range(1, 3);
        add_text("*");
        add_count(elems);
        for (int e = 0; e < elems; e++) begin
          len = $urandom_range(0, 6);
          add_text("$");
          add_count(len);
          for (int i = 0; i < len; i++) buf_byte(8'($urandom));
          if ($urandom_range(0, 3) == 0) begin
            buf_byte(8'($urandom));
            buf_byte(8'($urandom));
          end else begin
            add_crlf();
          end
        end
        n = $urandom_range(0, 9);
        if (n < 2) begin
          cut = $urandom_range(1, msg_buf.size() - 1);
          while (msg_buf.size() > cut) void'(msg_buf.pop_back());
        end else if (n == 2) begin
          msg_buf[$urandom_range(0, msg_buf.size() - 1)] = 8'($urandom);
        end else if (n == 3) begin
          add_text("junk");
        end
      end else if (pick < 85) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          n = $urandom_range(0, 9);
          if (n < 3) buf_byte(any_space());
          else if (n < 8) buf_byte(8'($urandom_range(8'h21, 8'h7E)));
          else buf_byte(8'($urandom));
        end
      end else begin
        if ($urandom_range(0, 1) == 1) buf_byte(ChStar);
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) buf_byte(8'($urandom));
      end
      send_message();
    end
    random_requests = sent_requests - start_count;
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    data_byte <= 8'h00;
    last <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_inline_split();
    drain();
    test_array_framing();
    drain();
    test_number_lines();
    drain();
    test_truncation();
    drain();
    test_backpressure();
    drain();
    test_random_traffic();
    drain();
    repeat (SettleCycles) @(posedge clk);

    if (due_results.size() != 0) begin
      errors += due_results.size();
      $display("ERROR: %0d expected results never arrived, oldest kind=%0d",
               due_results.size(), due_results[0].kind);
    end
    $display("Run: %0d messages in %0d byte requests (%0d random), %0d results checked.",
             messages_sent, sent_requests, random_requests, results_seen);
    $display("Covered inline splitting, array framing, number lines, truncation, stalls.");
    if (errors == 0) begin
      $display("** resp_command_tokenizer_core: PASSED **");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("** resp_command_tokenizer_core: FAILED **");
    end
    $finish;
  end

endmodule
